// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pwbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pwbt_pkg;

	// Angle datapath: heading scaled to 30 fraction bits, with headroom for the fold.
	localparam int ZW        = 34;
	localparam int ANG_SHIFT = 14;
	localparam int ATAN_N    = 24;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam longint               GAIN_Q30    = 64'sd652032874;

	// atan(2^-i) * 2^30, truncated
	localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// Values that ride alongside the CORDIC vector down the chain.
	typedef struct packed {
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [19:0] dh;
	} pwbt_side_t;

endpackage

`default_nettype wire

// ===== rtl/pose_world_to_body_transform_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// World-to-body transform of a target pose.
// Input: pulse start with goal_* and car_* valid in the same cycle; the
// transaction is taken on that edge, as busy is never raised. A new pose
// may be presented every cycle, so throughput is one pose per clock.
// The vehicle heading is folded into +-pi/2 and fed down a row of
// CORDIC_STAGES cells, one micro-rotation per cell, while the position
// differences ride alongside. Two further stages form the four products
// and then round, saturate and register the result.
// The folded heading and the differences are registered in a front stage ahead of the cell row.
// Output: done is high for exactly one cycle with body_x, body_y,
// body_heading and saturated; the receiver must take it then, there is
// no backpressure. saturated flags a clamp of body_x or body_y.
// Reset (arst_n low) empties the pipeline: transactions in flight are
// dropped and done stays low until a new start has travelled through.

`include "assert_macros.svh"

module pose_world_to_body_transform_core
	import pwbt_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS     = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] goal_x,
	input  wire logic signed [31:0] goal_y,
	input  wire logic signed [18:0] goal_heading,
	input  wire logic signed [31:0] car_x,
	input  wire logic signed [31:0] car_y,
	input  wire logic signed [18:0] car_heading,
	output logic                    done,
	output logic signed [31:0]      body_x,
	output logic signed [31:0]      body_y,
	output logic signed [19:0]      body_heading,
	output logic                    saturated
);

	localparam int     XW     = FRAC_BITS + 3;
	localparam int     LAT    = CORDIC_STAGES + 3;
	localparam longint X_INIT = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	localparam logic signed [XW-1:0] X0 = XW'(X_INIT);

	logic                 accept;
	logic signed [ZW-1:0] z_raw, z_fold;
	logic                 neg;
	pwbt_side_t           side_d;

	logic                 f_valid_s1;
	logic signed [ZW-1:0] f_z_s1;
	pwbt_side_t           f_side_s1;

	logic                 c_valid [CORDIC_STAGES+1];
	logic signed [XW-1:0] c_x     [CORDIC_STAGES+1];
	logic signed [XW-1:0] c_y     [CORDIC_STAGES+1];
	logic signed [ZW-1:0] c_z     [CORDIC_STAGES+1];
	pwbt_side_t           c_side  [CORDIC_STAGES+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		z_raw = {{(ZW-19-ANG_SHIFT){car_heading[18]}}, car_heading, {ANG_SHIFT{1'b0}}};
		neg   = 1'b0;
		z_fold = z_raw;
		if (z_raw > HALF_PI_Q30) begin
			z_fold = z_raw - PI_Q30;
			neg    = 1'b1;
		end else if (z_raw < -HALF_PI_Q30) begin
			z_fold = z_raw + PI_Q30;
			neg    = 1'b1;
		end
		// negating the differences stands in for negating cos and sin
		if (neg) begin
			side_d.dx = 34'(car_x) - 34'(goal_x);
			side_d.dy = 34'(car_y) - 34'(goal_y);
		end else begin
			side_d.dx = 34'(goal_x) - 34'(car_x);
			side_d.dy = 34'(goal_y) - 34'(car_y);
		end
		side_d.dh = 20'(goal_heading) - 20'(car_heading);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s1 <= 1'b0;
		end else begin
			f_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		f_z_s1    <= z_fold;
		f_side_s1 <= side_d;
	end

	assign c_valid[0] = f_valid_s1;
	assign c_x[0]     = X0;
	assign c_y[0]     = '0;
	assign c_z[0]     = f_z_s1;
	assign c_side[0]  = f_side_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		pwbt_cordic_cell #(
			.IDX (i),
			.XW  (XW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_x      (c_x[i]),
			.in_y      (c_y[i]),
			.in_z      (c_z[i]),
			.in_side   (c_side[i]),
			.out_valid (c_valid[i+1]),
			.out_x     (c_x[i+1]),
			.out_y     (c_y[i+1]),
			.out_z     (c_z[i+1]),
			.out_side  (c_side[i+1])
		);
	end

	pwbt_rotate #(
		.FRAC_BITS (FRAC_BITS),
		.XW        (XW)
	) u_rotate (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (c_valid[CORDIC_STAGES]),
		.cos_v        (c_x[CORDIC_STAGES]),
		.sin_v        (c_y[CORDIC_STAGES]),
		.side         (c_side[CORDIC_STAGES]),
		.done         (done),
		.body_x       (body_x),
		.body_y       (body_y),
		.body_heading (body_heading),
		.saturated    (saturated)
	);

	`ASSERT_IMPL(a_heading_lat, clk, arst_n, done,
		body_heading == $past(20'(goal_heading) - 20'(car_heading), LAT),
		"heading difference misaligned with its transaction")
	`ASSERT_IMPL(a_sat_clamp, clk, arst_n, done && saturated,
		(body_x == 32'sh7FFF_FFFF) || (body_x == 32'sh8000_0000) ||
		(body_y == 32'sh7FFF_FFFF) || (body_y == 32'sh8000_0000),
		"saturated flag without a clamped coordinate")

endmodule

`default_nettype wire

// ===== rtl/pwbt_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pwbt_cordic_cell
	import pwbt_pkg::*;
#(
	parameter int IDX = 0,
	parameter int XW  = 19
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic signed [XW-1:0] in_x,
	input  wire logic signed [XW-1:0] in_y,
	input  wire logic signed [ZW-1:0] in_z,
	input  wire pwbt_side_t           in_side,
	output logic                      out_valid,
	output logic signed [XW-1:0]      out_x,
	output logic signed [XW-1:0]      out_y,
	output logic signed [ZW-1:0]      out_z,
	output pwbt_side_t                out_side
);

	localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}}, ATAN_Q30[IDX]});

	logic                 valid_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	pwbt_side_t           side_q;

	logic signed [XW-1:0] xs, ys, x_d, y_d;
	logic signed [ZW-1:0] z_d;

	always_comb begin
		xs = in_x >>> IDX;
		ys = in_y >>> IDX;
		// rotate positive while the residual angle is non-negative
		if (!in_z[ZW-1]) begin
			x_d = in_x - ys;
			y_d = in_y + xs;
			z_d = in_z - ATAN;
		end else begin
			x_d = in_x + ys;
			y_d = in_y - xs;
			z_d = in_z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_d;
		y_q    <= y_d;
		z_q    <= z_d;
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

	// residual angle never leaves the convergence range once folded
	`ASSERT_IMPL(a_z_bound, clk, arst_n, valid_q,
		(z_q[ZW-1:31] == '0) || (z_q[ZW-1:31] == '1), "cordic residual out of range")

endmodule

`default_nettype wire

// ===== rtl/pwbt_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pwbt_rotate
	import pwbt_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int XW        = 19
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic signed [XW-1:0] cos_v,
	input  wire logic signed [XW-1:0] sin_v,
	input  wire pwbt_side_t           side,
	output logic                      done,
	output logic signed [31:0]        body_x,
	output logic signed [31:0]        body_y,
	output logic signed [19:0]        body_heading,
	output logic                      saturated
);

	localparam int PW = 34 + XW;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

	logic                 p_valid_s1;
	logic signed [PW-1:0] pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic signed [19:0]   dh_s1;

	logic                 done_s2;
	logic signed [31:0]   bx_s2, by_s2;
	logic signed [19:0]   dh_s2;
	logic                 sat_s2;

	logic signed [SW-1:0] sum_x, sum_y, r_x, r_y;
	logic                 fit_x, fit_y;
	logic signed [31:0]   bx_d, by_d;

	always_comb begin
		sum_x = SW'(pxc_s1) + SW'(pys_s1) + HALF;
		sum_y = SW'(pyc_s1) - SW'(pxs_s1) + HALF;
		r_x   = sum_x >>> FRAC_BITS;
		r_y   = sum_y >>> FRAC_BITS;
		fit_x = (r_x[SW-1:31] == '0) || (r_x[SW-1:31] == '1);
		fit_y = (r_y[SW-1:31] == '0) || (r_y[SW-1:31] == '1);
		// clamp toward the sign of the rounded result
		if (fit_x) begin
			bx_d = r_x[31:0];
		end else begin
			bx_d = r_x[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		if (fit_y) begin
			by_d = r_y[31:0];
		end else begin
			by_d = r_y[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_s1 <= 1'b0;
			done_s2    <= 1'b0;
		end else begin
			p_valid_s1 <= in_valid;
			done_s2    <= p_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pxc_s1 <= PW'(side.dx) * PW'(cos_v);
		pys_s1 <= PW'(side.dy) * PW'(sin_v);
		pyc_s1 <= PW'(side.dy) * PW'(cos_v);
		pxs_s1 <= PW'(side.dx) * PW'(sin_v);
		dh_s1  <= side.dh;
		bx_s2  <= bx_d;
		by_s2  <= by_d;
		dh_s2  <= dh_s1;
		sat_s2 <= !(fit_x && fit_y);
	end

	assign done         = done_s2;
	assign body_x       = bx_s2;
	assign body_y       = by_s2;
	assign body_heading = dh_s2;
	assign saturated    = sat_s2;

	`ASSERT_NEXT(a_prod_to_done, clk, arst_n, p_valid_s1, done_s2,
		"product stage lost its transaction")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int CORDIC_N    = 16;
	localparam int FRAC        = 16;
	localparam int RAND_POSES  = 850;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic signed [31:0] P_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] P_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE_M = 32'sh00010000;
	localparam logic signed [31:0] NEG_ONE_M = 32'shFFFF0000;
	localparam logic signed [31:0] ONE_HALF_M = 32'sh00018000;
	localparam logic signed [31:0] LSB_M = 32'sh00000001;
	localparam logic signed [31:0] NEG_LSB_M = 32'shFFFFFFFF;

	localparam logic signed [18:0] H_ZERO    = 19'sd0;
	localparam logic signed [18:0] H_PI      = 19'sd205887;
	localparam logic signed [18:0] H_NPI     = -19'sd205887;
	localparam logic signed [18:0] H_QPI     = 19'sd51472;
	localparam logic signed [18:0] H_HALF    = 19'sd102943;
	localparam logic signed [18:0] H_NHALF   = -19'sd102943;
	localparam logic signed [18:0] H_FOLD    = 19'sd102944;
	localparam logic signed [18:0] H_NFOLD   = -19'sd102944;
	localparam logic signed [18:0] H_TOP     = 19'sd262143;
	localparam logic signed [18:0] H_BOTTOM  = -19'sd262144;
	localparam logic signed [18:0] H_NLSB    = -19'sd1;

	localparam longint GAIN_Q30  = 64'sd652032874;
	localparam longint HALF_PI_A = 64'sd1686629713;
	localparam longint PI_A      = 64'sd3373259426;

	// arctangent steps, atan(2^-i) scaled by 2^30 and truncated
	localparam longint ATAN_STEP [CORDIC_N] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
	};

	typedef struct packed {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [18:0] gh;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [18:0] ch;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [19:0] bh;
		logic               sat;
	} body_t;

	typedef struct packed {
		pose_t p;
		logic  typed;
		body_t r;
	} pose_row_t;

	localparam int N_ROWS = 21;

	// typed rows have zero displacement, so only the heading difference can be non-zero
	localparam pose_row_t POSE_ROWS [N_ROWS] = '{
		'{'{32'sd0, 32'sd0, H_ZERO, 32'sd0, 32'sd0, H_ZERO}, 1'b1,
			'{32'sd0, 32'sd0, 20'sd0, 1'b0}},
		'{'{32'sd5, -32'sd7, H_PI, 32'sd5, -32'sd7, H_NPI}, 1'b1,
			'{32'sd0, 32'sd0, 20'sd411774, 1'b0}},
		'{'{P_MAX, P_MIN, H_NPI, P_MAX, P_MIN, H_PI}, 1'b1,
			'{32'sd0, 32'sd0, -20'sd411774, 1'b0}},
		'{'{NEG_LSB_M, NEG_LSB_M, H_BOTTOM, NEG_LSB_M, NEG_LSB_M, H_TOP}, 1'b1,
			'{32'sd0, 32'sd0, -20'sd524287, 1'b0}},
		'{'{32'sd0, 32'sd0, H_TOP, 32'sd0, 32'sd0, H_BOTTOM}, 1'b1,
			'{32'sd0, 32'sd0, 20'sd524287, 1'b0}},
		'{'{P_MAX, 32'sd0, H_ZERO, P_MIN, 32'sd0, H_ZERO}, 1'b0, '0},
		'{'{P_MIN, 32'sd0, H_ZERO, P_MAX, 32'sd0, H_ZERO}, 1'b0, '0},
		'{'{32'sd0, P_MAX, H_ZERO, 32'sd0, P_MIN, H_ZERO}, 1'b0, '0},
		'{'{P_MAX, P_MAX, H_PI, P_MIN, P_MIN, H_QPI}, 1'b0, '0},
		'{'{ONE_M, 32'sd0, H_ZERO, 32'sd0, 32'sd0, H_HALF}, 1'b0, '0},
		'{'{ONE_M, 32'sd0, H_ZERO, 32'sd0, 32'sd0, H_FOLD}, 1'b0, '0},
		'{'{32'sd0, ONE_M, H_ZERO, 32'sd0, 32'sd0, H_NHALF}, 1'b0, '0},
		'{'{32'sd0, ONE_M, H_ZERO, 32'sd0, 32'sd0, H_NFOLD}, 1'b0, '0},
		'{'{ONE_M, ONE_M, H_ZERO, 32'sd0, 32'sd0, H_PI}, 1'b0, '0},
		'{'{ONE_M, ONE_M, H_ZERO, 32'sd0, 32'sd0, H_NPI}, 1'b0, '0},
		'{'{ONE_M, NEG_ONE_M, H_ZERO, 32'sd0, 32'sd0, H_TOP}, 1'b0, '0},
		'{'{ONE_M, NEG_ONE_M, H_ZERO, 32'sd0, 32'sd0, H_BOTTOM}, 1'b0, '0},
		'{'{NEG_LSB_M, 32'sd0, H_ZERO, 32'sd0, 32'sd0, H_ZERO}, 1'b0, '0},
		'{'{LSB_M, LSB_M, H_ZERO, 32'sd0, 32'sd0, H_NLSB}, 1'b0, '0},
		'{'{P_MIN, P_MIN, H_NPI, P_MAX, P_MAX, H_NPI}, 1'b0, '0},
		'{'{ONE_HALF_M, 32'sd0, H_ZERO, 32'sd0, 32'sd0, H_ZERO}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] goal_x = '0;
	logic signed [31:0] goal_y = '0;
	logic signed [18:0] goal_heading = '0;
	logic signed [31:0] car_x = '0;
	logic signed [31:0] car_y = '0;
	logic signed [18:0] car_heading = '0;
	logic busy;
	logic done;
	logic signed [31:0] body_x;
	logic signed [31:0] body_y;
	logic signed [19:0] body_heading;
	logic saturated;

	body_t pending_body [$];
	int    mismatches = 0;
	int    cycle_count = 0;
	int    burst_left = 0;

	pose_world_to_body_transform_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.goal_x       (goal_x),
		.goal_y       (goal_y),
		.goal_heading (goal_heading),
		.car_x        (car_x),
		.car_y        (car_y),
		.car_heading  (car_heading),
		.done         (done),
		.body_x       (body_x),
		.body_y       (body_y),
		.body_heading (body_heading),
		.saturated    (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [31:0] round_clamp(input longint acc, inout logic clamp);
		longint r;
		r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
		if (r > 64'sd2147483647) begin
			clamp = 1'b1;
			return P_MAX;
		end
		if (r < -64'sd2147483648) begin
			clamp = 1'b1;
			return P_MIN;
		end
		return r[31:0];
	endfunction

	function automatic body_t body_frame_of(input pose_t p);
		longint ang, cs, sn, xs, ys, dx, dy;
		logic   flip;
		logic   clamp;
		body_t  r;
		ang = longint'($signed(p.ch)) * 64'sd16384;
		flip = 1'b0;
		clamp = 1'b0;
		// fold into +-pi/2 and negate the vector afterwards
		if (ang > HALF_PI_A) begin
			ang = ang - PI_A;
			flip = 1'b1;
		end else if (ang < -HALF_PI_A) begin
			ang = ang + PI_A;
			flip = 1'b1;
		end
		cs = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		sn = 0;
		for (int i = 0; i < CORDIC_N; i++) begin
			xs = cs >>> i;
			ys = sn >>> i;
			if (ang >= 0) begin
				cs = cs - ys;
				sn = sn + xs;
				ang = ang - ATAN_STEP[i];
			end else begin
				cs = cs + ys;
				sn = sn - xs;
				ang = ang + ATAN_STEP[i];
			end
		end
		if (flip) begin
			cs = -cs;
			sn = -sn;
		end
		dx = longint'($signed(p.gx)) - longint'($signed(p.cx));
		dy = longint'($signed(p.gy)) - longint'($signed(p.cy));
		r.bx = round_clamp(dx * cs + dy * sn, clamp);
		r.by = round_clamp(dy * cs - dx * sn, clamp);
		r.bh = 20'(longint'($signed(p.gh)) - longint'($signed(p.ch)));
		r.sat = clamp;
		return r;
	endfunction

	function automatic logic signed [18:0] random_heading();
		// now and then the whole bit range, beyond +-pi
		if ($urandom_range(0, 9) == 0)
			return 19'($urandom);
		return 19'(int'($urandom_range(0, 411774)) - 205887);
	endfunction

	function automatic logic signed [31:0] random_extreme();
		case ($urandom_range(0, 3))
			0: return P_MAX;
			1: return P_MIN;
			2: return 32'sd0;
			default: return NEG_LSB_M;
		endcase
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int    kind;
		kind = $urandom_range(0, 9);
		p.gh = random_heading();
		p.ch = random_heading();
		p.cx = 32'($urandom);
		p.cy = 32'($urandom);
		if (kind < 3) begin
			p.gx = 32'($urandom);
			p.gy = 32'($urandom);
		end else if (kind < 8) begin
			// target within a few tens of metres of the vehicle
			p.gx = p.cx + 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
			p.gy = p.cy + 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
		end else if (kind == 8) begin
			p.gx = random_extreme();
			p.gy = random_extreme();
			p.cx = random_extreme();
			p.cy = random_extreme();
		end else begin
			p.gx = p.cx;
			p.gy = p.cy;
		end
		return p;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// one transaction, then, when a burst ends, an idle gap that may be empty
	task automatic send_pose(input pose_t p, input logic typed, input body_t typed_body);
		int    gap;
		body_t want_body;
		start <= 1'b1;
		goal_x <= p.gx;
		goal_y <= p.gy;
		goal_heading <= p.gh;
		car_x <= p.cx;
		car_y <= p.cy;
		car_heading <= p.ch;
		do
			@(posedge clk);
		while (busy);
		want_body = typed ? typed_body : body_frame_of(p);
		pending_body = {pending_body, want_body};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
				: $urandom_range(0, 12);
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 23);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	always @(posedge clk) begin
		body_t want;
		if (arst_n && done) begin
			if (pending_body.size() == 0) begin
				$display("%0t: result with no transaction outstanding, body_x %0d body_y %0d",
					$time, body_x, body_y);
				mismatches++;
			end else begin
				want = pending_body.pop_front();
				check_field("body_x", want.bx, body_x);
				check_field("body_y", want.by, body_y);
				check_field("body_heading", want.bh, body_heading);
				if (saturated !== want.sat) begin
					$display("%0t: saturated mismatch, expected %0b, actual %b",
						$time, want.sat, saturated);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pose_world_to_body_transform_core test failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_pose(POSE_ROWS[i].p, POSE_ROWS[i].typed, POSE_ROWS[i].r);

		for (int i = 0; i < RAND_POSES; i++) begin
			send_pose(random_pose(), 1'b0, '0);
			// hold off until the pipeline has emptied
			if (i == RAND_POSES / 2 || $urandom_range(0, 199) == 0) begin
				start <= 1'b0;
				while (pending_body.size() != 0)
					@(posedge clk);
			end
		end

		start <= 1'b0;
		while (pending_body.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("pose_world_to_body_transform_core test passed");
		else
			$display("pose_world_to_body_transform_core test failed");
		$finish;
	end

endmodule
